// ===== design/heading_pid_differential_drive_unit_defines.svh =====
// Assertion macros for the heading PID differential drive unit.
// Expects clk and rst in the scope of each use.
`ifndef HEADING_PID_DIFFERENTIAL_DRIVE_UNIT_DEFINES_SVH
`define HEADING_PID_DIFFERENTIAL_DRIVE_UNIT_DEFINES_SVH

// same-cycle implication
`define HPDD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define HPDD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/hpdd_pkg.sv =====
// Package for the heading PID differential drive unit: widths, constants,
// control word and status types, and the microcode program. No dependencies.
package hpdd_pkg;

  localparam int HeadW  = 15;
  localparam int TimeW  = 32;
  localparam int GainW  = 16;
  localparam int ErrW   = 16;
  localparam int DtW    = 16;
  localparam int DivW   = 17;
  localparam int MulW   = 17;
  localparam int ProdW  = 2 * MulW;
  localparam int IntW   = 48;
  localparam int AccW   = 64;
  localparam int SpeedW = 8;
  localparam int CfgIdxW = 2;
  localparam int StepW  = 4;
  localparam int DivCntW = 5;

  localparam logic [CfgIdxW-1:0] CfgPropGain  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgIntegGain = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgDerivGain = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgTarget    = 2'd3;

  localparam logic [SpeedW-1:0] Neutral  = 8'd92;
  localparam logic [SpeedW-1:0] SpeedMax = 8'd142;
  localparam logic [SpeedW-1:0] SpeedMin = 8'd42;
  localparam logic [SpeedW:0]   SpeedPairSum = 9'd184;
  localparam logic signed [SpeedW-1:0] DriveLimit = 8'sd50;
  localparam logic signed [AccW-1:0] DriveLimitWide = 64'sd50;

  localparam logic signed [AccW-1:0] TermLimit = 64'sh0000_0100_0000_0000;
  localparam logic signed [IntW:0] IntMax = 49'sh0_7FFF_FFFF_FFFF;
  localparam logic signed [IntW:0] IntMin = 49'sh1_8000_0000_0000;

  localparam logic [DivCntW-1:0] DivSteps = 5'd17;
  localparam logic [DivCntW-1:0] DivLast  = 5'd1;

  localparam logic [StepW-1:0] StepDivLoop = 4'd2;
  localparam logic [StepW-1:0] StepDivDone = 4'd3;

  typedef enum logic [1:0] {A_DT, A_PROP, A_INTEG, A_DERIV} mul_a_sel_t;
  typedef enum logic [2:0] {B_ERR, B_INT0, B_INT1, B_INT2, B_DERIV} mul_b_sel_t;
  typedef enum logic [2:0] {
    ACC_NONE, ACC_LOAD, ACC_ADD0, ACC_ADD16, ACC_ADD32, ACC_CLAMP
  } acc_op_t;
  typedef enum logic [1:0] {DIV_NONE, DIV_INIT, DIV_STEP, DIV_DONE} div_op_t;
  typedef enum logic [1:0] {JMP_NONE, JMP_DT_ZERO, JMP_DIV_MORE} jump_t;

  typedef struct packed {
    mul_a_sel_t       a_sel;
    mul_b_sel_t       b_sel;
    logic             mul_en;
    acc_op_t          acc_op;
    logic             int_upd;
    div_op_t          div_op;
    logic             out_load;
    jump_t            jump;
    logic [StepW-1:0] target;
    logic             fin;
  } ctrl_t;

  typedef struct packed {
    logic dt_zero;
    logic div_more;
    logic out_full;
  } stat_t;

  localparam ctrl_t CtrlNop = '{
    a_sel: A_DT, b_sel: B_ERR, mul_en: 1'b0, acc_op: ACC_NONE, int_upd: 1'b0,
    div_op: DIV_NONE, out_load: 1'b0, jump: JMP_NONE, target: '0, fin: 1'b0
  };

  function automatic ctrl_t ucode(input logic [StepW-1:0] step);
    ctrl_t w;
    w = CtrlNop;
    case (step)
      4'd0: begin
        w.a_sel = A_DT; w.b_sel = B_ERR; w.mul_en = 1'b1;
      end
      4'd1: begin
        w.int_upd = 1'b1; w.div_op = DIV_INIT;
        w.jump = JMP_DT_ZERO; w.target = StepDivDone;
      end
      4'd2: begin
        w.div_op = DIV_STEP; w.jump = JMP_DIV_MORE; w.target = StepDivLoop;
      end
      4'd3: begin
        w.div_op = DIV_DONE;
        w.a_sel = A_INTEG; w.b_sel = B_INT0; w.mul_en = 1'b1;
      end
      4'd4: begin
        w.acc_op = ACC_LOAD;
        w.a_sel = A_INTEG; w.b_sel = B_INT1; w.mul_en = 1'b1;
      end
      4'd5: begin
        w.acc_op = ACC_ADD16;
        w.a_sel = A_INTEG; w.b_sel = B_INT2; w.mul_en = 1'b1;
      end
      4'd6: begin
        w.acc_op = ACC_ADD32;
        w.a_sel = A_PROP; w.b_sel = B_ERR; w.mul_en = 1'b1;
      end
      4'd7: begin
        w.acc_op = ACC_CLAMP;
      end
      4'd8: begin
        w.acc_op = ACC_ADD0;
        w.a_sel = A_DERIV; w.b_sel = B_DERIV; w.mul_en = 1'b1;
      end
      4'd9: begin
        w.acc_op = ACC_ADD0;
      end
      4'd10: begin
        w.out_load = 1'b1; w.fin = 1'b1;
      end
      default: begin
        w.fin = 1'b1;
      end
    endcase
    return w;
  endfunction

endpackage

// ===== design/hpdd_channels_if.sv =====
// Handshake channel interfaces for the heading PID differential drive unit.
// Depends on hpdd_pkg for field widths.
interface hpdd_in_if;
  import hpdd_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [HeadW-1:0] heading;
  logic [TimeW-1:0]        time_seconds;
  modport source (output valid, output heading, output time_seconds, input ready);
  modport sink (input valid, input heading, input time_seconds, output ready);
endinterface

interface hpdd_out_if;
  import hpdd_pkg::*;
  logic              valid;
  logic              ready;
  logic [SpeedW-1:0] left_speed;
  logic [SpeedW-1:0] right_speed;
  logic              drive_clamped;
  modport source (output valid, output left_speed, output right_speed,
                  output drive_clamped, input ready);
  modport sink (input valid, input left_speed, input right_speed,
                input drive_clamped, output ready);
endinterface

// ===== design/hpdd_seq.sv =====
// Microcode sequencer: step counter, program table lookup, conditional jumps.
// Depends on hpdd_pkg for the control word, status and program.
module hpdd_seq (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  hpdd_pkg::stat_t stat,
  output hpdd_pkg::ctrl_t ctrl,
  output logic            ready
);
  import hpdd_pkg::*;

  logic             busy;
  logic             busy_next;
  logic [StepW-1:0] step;
  logic [StepW-1:0] step_next;
  ctrl_t            word;
  logic             stall;
  logic             taken;

  always_comb begin
    word  = ucode(step);
    stall = word.out_load && stat.out_full;
    taken = (word.jump == JMP_DT_ZERO && stat.dt_zero) ||
            (word.jump == JMP_DIV_MORE && stat.div_more);
    ctrl  = (busy && !stall) ? word : CtrlNop;
    ready = !busy && !rst;
    busy_next = busy;
    step_next = step;
    if (!busy) begin
      if (start) begin
        busy_next = 1'b1;
        step_next = '0;
      end
    end else if (!stall) begin
      if (word.fin) begin
        busy_next = 1'b0;
      end else if (taken) begin
        step_next = word.target;
      end else begin
        step_next = step + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else begin
      busy <= busy_next;
      step <= step_next;
    end
  end

endmodule

// ===== design/hpdd_datapath.sv =====
// Datapath: configuration registers, input capture, shared multiplier,
// accumulator, serial divider and output register. Depends on hpdd_pkg.
module hpdd_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [hpdd_pkg::CfgIdxW-1:0]        cfg_index,
  input  logic [hpdd_pkg::GainW-1:0]          cfg_wdata,
  input  logic                                start,
  input  logic signed [hpdd_pkg::HeadW-1:0]   heading,
  input  logic [hpdd_pkg::TimeW-1:0]          time_seconds,
  input  hpdd_pkg::ctrl_t                     ctrl,
  output hpdd_pkg::stat_t                     stat,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic [hpdd_pkg::SpeedW-1:0]         left_speed,
  output logic [hpdd_pkg::SpeedW-1:0]         right_speed,
  output logic                                drive_clamped
);
  import hpdd_pkg::*;

  logic [GainW-1:0]        prop_gain;
  logic [GainW-1:0]        integ_gain;
  logic [GainW-1:0]        deriv_gain;
  logic signed [HeadW-1:0] heading_target;

  logic signed [IntW-1:0]  integral_sum;
  logic signed [ErrW-1:0]  last_error;
  logic [TimeW-1:0]        last_time;

  logic signed [ErrW-1:0]  err;
  logic signed [DivW-1:0]  de;
  logic [DtW-1:0]          dt;
  logic signed [DivW-1:0]  deriv;

  logic signed [ErrW-1:0]  error_w;
  logic signed [DivW-1:0]  de_w;
  logic [TimeW-1:0]        diff_w;
  logic [DtW-1:0]          dt_w;

  logic signed [MulW-1:0]  mul_a;
  logic signed [MulW-1:0]  mul_b;
  logic signed [ProdW-1:0] prod;
  logic signed [AccW-1:0]  prod_wide;
  logic signed [AccW-1:0]  acc;
  logic signed [AccW-1:0]  acc_next;
  logic signed [IntW:0]    int_sum_w;

  logic [DivW-1:0]         div_rem;
  logic [DivW-1:0]         div_quo;
  logic [DivCntW-1:0]      div_cnt;
  logic [DivW-1:0]         rem_sh;
  logic [DivW-1:0]         rem_sub;
  logic [DivW-1:0]         de_abs;

  logic signed [AccW-1:0]  drive_full;
  logic signed [SpeedW-1:0] drive;
  logic                    over;

  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain      <= '0;
      integ_gain     <= '0;
      deriv_gain     <= '0;
      heading_target <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CfgPropGain:  prop_gain      <= cfg_wdata;
        CfgIntegGain: integ_gain     <= cfg_wdata;
        CfgDerivGain: deriv_gain     <= cfg_wdata;
        CfgTarget:    heading_target <= cfg_wdata[HeadW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    error_w = {heading_target[HeadW-1], heading_target} - {heading[HeadW-1], heading};
    de_w    = {error_w[ErrW-1], error_w} - {last_error[ErrW-1], last_error};
    diff_w  = time_seconds - last_time;
    dt_w    = (|diff_w[TimeW-1:DtW]) ? {DtW{1'b1}} : diff_w[DtW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_error <= '0;
      last_time  <= '0;
    end else if (start) begin
      last_error <= error_w;
      last_time  <= time_seconds;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      err <= error_w;
      de  <= de_w;
      dt  <= dt_w;
    end
  end

  always_comb begin
    case (ctrl.a_sel)
      A_DT:    mul_a = {1'b0, dt};
      A_PROP:  mul_a = {1'b0, prop_gain};
      A_INTEG: mul_a = {1'b0, integ_gain};
      A_DERIV: mul_a = {1'b0, deriv_gain};
      default: mul_a = '0;
    endcase
    case (ctrl.b_sel)
      B_ERR:   mul_b = {err[ErrW-1], err};
      B_INT0:  mul_b = {1'b0, integral_sum[15:0]};
      B_INT1:  mul_b = {1'b0, integral_sum[31:16]};
      B_INT2:  mul_b = {integral_sum[IntW-1], integral_sum[IntW-1:32]};
      B_DERIV: mul_b = deriv;
      default: mul_b = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod <= mul_a * mul_b;
    end
  end

  assign int_sum_w = {integral_sum[IntW-1], integral_sum} +
                     {{(IntW + 1 - ProdW){prod[ProdW-1]}}, prod};

  always_ff @(posedge clk) begin
    if (rst) begin
      integral_sum <= '0;
    end else if (ctrl.int_upd) begin
      if (int_sum_w > IntMax) begin
        integral_sum <= IntMax[IntW-1:0];
      end else if (int_sum_w < IntMin) begin
        integral_sum <= IntMin[IntW-1:0];
      end else begin
        integral_sum <= int_sum_w[IntW-1:0];
      end
    end
  end

  always_comb begin
    prod_wide = {{(AccW - ProdW){prod[ProdW-1]}}, prod};
    case (ctrl.acc_op)
      ACC_LOAD:  acc_next = prod_wide;
      ACC_ADD0:  acc_next = acc + prod_wide;
      ACC_ADD16: acc_next = acc + (prod_wide <<< 16);
      ACC_ADD32: acc_next = acc + (prod_wide <<< 32);
      ACC_CLAMP: begin
        if (acc > TermLimit) begin
          acc_next = TermLimit;
        end else if (acc < -TermLimit) begin
          acc_next = -TermLimit;
        end else begin
          acc_next = acc;
        end
      end
      default: acc_next = acc;
    endcase
  end

  always_ff @(posedge clk) begin
    acc <= acc_next;
  end

  always_comb begin
    de_abs  = de[DivW-1] ? DivW'(-de) : DivW'(de);
    rem_sh  = {div_rem[DivW-2:0], div_quo[DivW-1]};
    rem_sub = rem_sh - {1'b0, dt};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else begin
      case (ctrl.div_op)
        DIV_INIT: div_cnt <= DivSteps;
        DIV_STEP: div_cnt <= div_cnt - 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (ctrl.div_op)
      DIV_INIT: begin
        div_rem <= '0;
        div_quo <= de_abs;
      end
      DIV_STEP: begin
        if (rem_sh >= {1'b0, dt}) begin
          div_rem <= rem_sub;
          div_quo <= {div_quo[DivW-2:0], 1'b1};
        end else begin
          div_rem <= rem_sh;
          div_quo <= {div_quo[DivW-2:0], 1'b0};
        end
      end
      DIV_DONE: begin
        if (dt == '0) begin
          deriv <= '0;
        end else if (de[DivW-1]) begin
          deriv <= -$signed(div_quo);
        end else begin
          deriv <= $signed(div_quo);
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    drive_full = acc >>> 8;
    over = 1'b0;
    if (drive_full > DriveLimitWide) begin
      drive = DriveLimit;
      over  = 1'b1;
    end else if (drive_full < -DriveLimitWide) begin
      drive = -DriveLimit;
      over  = 1'b1;
    end else begin
      drive = drive_full[SpeedW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      left_speed    <= Neutral + drive;
      right_speed   <= Neutral - drive;
      drive_clamped <= over;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_comb begin
    stat.dt_zero  = (dt == '0);
    stat.div_more = (div_cnt != DivLast);
    stat.out_full = out_valid && !out_ready;
  end

endmodule

// ===== design/heading_pid_differential_drive_unit.sv =====
// Heading PID controller with differential thrust mixing. An accepted item
// (heading, timestamp) yields one item of left and right thruster commands
// around neutral 92, clamped to 42..142, with a flag when the drive was
// limited to plus or minus 50. A short microcode program drives one shared
// 17x17 multiplier, a 64-bit accumulator and a one-bit-per-cycle divider for
// the derivative. The time to a result is set by the 17 divider steps and the
// six multiplies; a zero elapsed time skips the divider steps. The next item
// is accepted in the same cycle that the result appears at the earliest, and
// no new item is taken while the program for the last one still runs.
// A result still waiting in the output register holds the next program at
// its last step until it is taken.
// Depends on hpdd_pkg, the channel interfaces, hpdd_seq and hpdd_datapath.
`include "heading_pid_differential_drive_unit_defines.svh"

module heading_pid_differential_drive_unit (
  input  logic                         clk,
  input  logic                         rst,
  hpdd_in_if.sink                      in_ch,
  hpdd_out_if.source                   out_ch,
  input  logic                         cfg_we,
  input  logic [hpdd_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [hpdd_pkg::GainW-1:0]   cfg_wdata
);
  import hpdd_pkg::*;

  ctrl_t ctrl;
  stat_t stat;
  logic  seq_ready;
  logic  start;
  logic  speed_in_range;
  logic  speed_mirrored;
  logic  speed_at_limit;

  assign start       = in_ch.valid && seq_ready;
  assign in_ch.ready = seq_ready;

  hpdd_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .ctrl  (ctrl),
    .ready (seq_ready)
  );

  hpdd_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .start         (start),
    .heading       (in_ch.heading),
    .time_seconds  (in_ch.time_seconds),
    .ctrl          (ctrl),
    .stat          (stat),
    .out_ready     (out_ch.ready),
    .out_valid     (out_ch.valid),
    .left_speed    (out_ch.left_speed),
    .right_speed   (out_ch.right_speed),
    .drive_clamped (out_ch.drive_clamped)
  );

  assign speed_in_range = out_ch.left_speed >= SpeedMin && out_ch.left_speed <= SpeedMax &&
                          out_ch.right_speed >= SpeedMin && out_ch.right_speed <= SpeedMax;
  assign speed_mirrored = ({1'b0, out_ch.left_speed} + {1'b0, out_ch.right_speed}) ==
                          SpeedPairSum;
  assign speed_at_limit = out_ch.left_speed == SpeedMin || out_ch.left_speed == SpeedMax;

  `HPDD_ASSERT_NEXT(a_busy_after_accept, in_ch.valid && in_ch.ready, !in_ch.ready, "busy")
  `HPDD_ASSERT_NOW(a_speed_range, out_ch.valid, speed_in_range, "command out of range")
  `HPDD_ASSERT_NOW(a_speed_mirror, out_ch.valid, speed_mirrored, "commands not mirrored")
  `HPDD_ASSERT_NOW(a_clamp_edge, out_ch.valid && out_ch.drive_clamped, speed_at_limit, "clamp")

endmodule
